@@ sv/imu_tof_distance_estimator_assert.svh @@
// ----------------------------------------------------------------------------
// IMU/ToF distance estimator assertion macros
// Shared property wrappers for the estimator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef IMU_TOF_DISTANCE_ESTIMATOR_ASSERT_SVH
`define IMU_TOF_DISTANCE_ESTIMATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define ITDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ITDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/itde_pkg.sv @@
// ----------------------------------------------------------------------------
// IMU/ToF distance estimator package
// Types and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package itde_pkg;

    localparam logic [1:0] ACT_IMU     = 2'd0;
    localparam logic [1:0] ACT_PREDICT = 2'd1;
    localparam logic [1:0] ACT_RANGE   = 2'd2;

    localparam logic [1:0] REG_DELTA_TIME = 2'd0;
    localparam logic [1:0] REG_DEADBAND   = 2'd1;
    localparam logic [1:0] REG_MOTION     = 2'd2;

    localparam int          SQRT_STEPS = 17;
    localparam logic [15:0] GRAVITY_MG = 16'd1000;
    localparam logic [11:0] SCALE_Q8   = 12'd2511;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_ACCEL,
        ST_VEL_MUL,
        ST_VEL_ADD,
        ST_RING_SUM,
        ST_AVG,
        ST_PRED_MUL,
        ST_PRED_ADD,
        ST_OUT
    } t_state;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic accel;
        logic vel_mul;
        logic vel_add;
        logic ring_clr;
        logic ring_acc;
        logic avg;
        logic pred_mul;
        logic pred_add;
        logic range_ld;
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic moving;
    } t_status;

endpackage

@@ sv/itde_ctrl.sv @@
// ----------------------------------------------------------------------------
// IMU/ToF distance estimator controller
// Sequences the square root, integration, ring averaging, prediction and output steps.
// ----------------------------------------------------------------------------
module itde_ctrl #(
    parameter int AVG_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_action,
    input  logic               i_out_taken,
    input  itde_pkg::t_status  i_status,
    output itde_pkg::t_cmd     o_cmd,
    output logic               o_idle,
    output logic               o_out_valid
);

    localparam int CW = $clog2(AVG_DEPTH + itde_pkg::SQRT_STEPS + 1);

    itde_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itde_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            itde_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_cnt = '0;
                    priority if (i_action == itde_pkg::ACT_IMU)
                        n_state = itde_pkg::ST_SQRT;
                    else if (i_action == itde_pkg::ACT_PREDICT)
                        n_state = i_status.moving ? itde_pkg::ST_PRED_MUL
                                                  : itde_pkg::ST_OUT;
                    else
                        n_state = itde_pkg::ST_OUT;
                end
            end
            itde_pkg::ST_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(itde_pkg::SQRT_STEPS - 1)) begin
                    n_state = itde_pkg::ST_ACCEL;
                end
            end
            itde_pkg::ST_ACCEL: begin
                n_state = itde_pkg::ST_VEL_MUL;
            end
            itde_pkg::ST_VEL_MUL: begin
                n_state = itde_pkg::ST_VEL_ADD;
            end
            itde_pkg::ST_VEL_ADD: begin
                n_cnt   = '0;
                n_state = itde_pkg::ST_RING_SUM;
            end
            itde_pkg::ST_RING_SUM: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(AVG_DEPTH - 1)) begin
                    n_state = itde_pkg::ST_AVG;
                end
            end
            itde_pkg::ST_AVG:      n_state = itde_pkg::ST_OUT;
            itde_pkg::ST_PRED_MUL: n_state = itde_pkg::ST_PRED_ADD;
            itde_pkg::ST_PRED_ADD: n_state = itde_pkg::ST_OUT;
            itde_pkg::ST_OUT: begin
                if (i_out_taken) n_state = itde_pkg::ST_IDLE;
            end
            default: n_state = itde_pkg::ST_IDLE;
        endcase
    end

    // Command decode.
    always_comb begin
        o_cmd       = '0;
        o_idle      = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            itde_pkg::ST_IDLE: begin
                o_idle       = 1'b1;
                o_cmd.load   = i_start;
                o_cmd.range_ld = i_start && (i_action == itde_pkg::ACT_RANGE);
            end
            itde_pkg::ST_SQRT:     o_cmd.sqrt_step = 1'b1;
            itde_pkg::ST_ACCEL:    o_cmd.accel     = 1'b1;
            itde_pkg::ST_VEL_MUL:  o_cmd.vel_mul   = 1'b1;
            itde_pkg::ST_VEL_ADD: begin
                o_cmd.vel_add  = 1'b1;
                o_cmd.ring_clr = 1'b1;
            end
            itde_pkg::ST_RING_SUM: o_cmd.ring_acc  = 1'b1;
            itde_pkg::ST_AVG:      o_cmd.avg       = 1'b1;
            itde_pkg::ST_PRED_MUL: o_cmd.pred_mul  = 1'b1;
            itde_pkg::ST_PRED_ADD: o_cmd.pred_add  = 1'b1;
            itde_pkg::ST_OUT:      o_out_valid     = 1'b1;
            default: ;
        endcase
    end

endmodule

@@ sv/itde_dpath.sv @@
// ----------------------------------------------------------------------------
// IMU/ToF distance estimator datapath
// Square root, fixed-point integrators, velocity ring and output registers.
// ----------------------------------------------------------------------------
module itde_dpath #(
    parameter int AVG_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  itde_pkg::t_cmd     i_cmd,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic [15:0]        i_range_reading,
    input  logic [15:0]        i_range_error,
    input  logic [15:0]        i_delta_time,
    input  logic [15:0]        i_deadband_limit,
    input  logic [15:0]        i_motion_threshold,
    output itde_pkg::t_status  o_status,
    output logic signed [31:0] o_accel,
    output logic signed [31:0] o_velocity,
    output logic signed [31:0] o_velocity_avg,
    output logic signed [31:0] o_estimate,
    output logic signed [31:0] o_delta,
    output logic [15:0]        o_range,
    output logic [15:0]        o_range_error
);

    localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SW = 32 + $clog2(AVG_DEPTH) + 1;
    localparam logic [PW-1:0] LAST_PTR = PW'(AVG_DEPTH - 1);

    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    // Saturate a 34-bit signed sum to 32 bits.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) return MAX32;
        if (v < -34'sh0_8000_0000) return MIN32;
        return v[31:0];
    endfunction

    logic signed [31:0] r_accel, r_vel, r_avg, r_est, r_delta;
    logic [15:0]        r_range, r_rerr;
    logic signed [31:0] r_ring [AVG_DEPTH];
    logic [PW-1:0]      r_ptr, r_rd;
    logic [33:0]        r_rem;
    logic [33:0]        r_root;
    logic [33:0]        r_bit;
    logic signed [48:0] r_prod;
    logic signed [SW-1:0] r_sum;
    logic               r_dead;

    logic [33:0] sq_sum;
    logic signed [16:0] mag_off;
    logic signed [29:0] acc_full;
    logic signed [31:0] lim_q8;
    logic signed [32:0] inc;
    logic signed [33:0] vel_sum, delta_sum, est_sum, avg_sum;
    logic signed [SW-1:0] mean;
    logic [33:0] trial;

    // Sum of squares, root trial, scaled acceleration and integrator sums.
    always_comb begin
        sq_sum = 34'(unsigned'(32'(i_accel_x * i_accel_x)))
               + 34'(unsigned'(32'(i_accel_y * i_accel_y)))
               + 34'(unsigned'(32'(i_accel_z * i_accel_z)));
        trial    = r_root + r_bit;
        mag_off  = 17'(signed'({1'b0, r_root[15:0]}))
                 - 17'(signed'({1'b0, itde_pkg::GRAVITY_MG}));
        acc_full = 30'(mag_off) * 30'(signed'({1'b0, itde_pkg::SCALE_Q8}));
        lim_q8   = signed'({8'd0, i_deadband_limit, 8'd0});
        // Floor shift of the product is an arithmetic shift.
        inc       = 33'(r_prod >>> 16);
        vel_sum   = 34'(r_vel) + 34'(inc);
        delta_sum = 34'(r_delta) + 34'(inc);
        est_sum   = 34'(signed'({10'd0, r_range, 8'd0})) + 34'(sat34(delta_sum));
        mean      = r_sum / AVG_DEPTH;
        avg_sum   = 34'(r_avg) + 34'(mean);
    end

    assign o_status.moving =
        r_vel > signed'({8'd0, i_motion_threshold, 8'd0});

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= '0;
            r_vel   <= '0;
            r_avg   <= '0;
            r_est   <= '0;
            r_delta <= '0;
            r_range <= '0;
            r_rerr  <= '0;
            r_ptr   <= '0;
            for (int i = 0; i < AVG_DEPTH; i++) r_ring[i] <= '0;
        end else begin
            if (i_cmd.load) begin
                r_rem  <= sq_sum;
                r_root <= '0;
                r_bit  <= 34'h1 << 32;
            end
            // One bit of the root per step.
            if (i_cmd.sqrt_step) begin
                if (r_rem >= trial) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            if (i_cmd.accel) begin
                r_accel <= 32'(acc_full);
                r_dead  <= (32'(acc_full) <= lim_q8) && (32'(acc_full) >= -lim_q8);
            end
            if (i_cmd.vel_mul) r_prod <= r_accel * signed'({1'b0, i_delta_time});
            if (i_cmd.vel_add) begin
                if (r_dead) begin
                    r_vel <= '0;
                    r_avg <= '0;
                    r_ring[r_ptr] <= '0;
                end else begin
                    r_vel <= sat34(vel_sum);
                    r_ring[r_ptr] <= sat34(vel_sum);
                end
                r_ptr <= (r_ptr == LAST_PTR) ? '0 : r_ptr + 1'b1;
            end
            if (i_cmd.ring_clr) begin
                r_sum <= '0;
                r_rd  <= '0;
            end
            // Ring sum, one entry per cycle.
            if (i_cmd.ring_acc) begin
                r_sum <= r_sum + SW'(r_ring[r_rd]);
                r_rd  <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_cmd.avg) r_avg <= sat34(avg_sum);
            if (i_cmd.load && i_action == itde_pkg::ACT_PREDICT && !o_status.moving) begin
                r_delta <= '0;
                r_est   <= signed'({8'd0, r_range, 8'd0});
            end
            if (i_cmd.pred_mul) r_prod <= r_vel * signed'({1'b0, i_delta_time});
            if (i_cmd.pred_add) begin
                r_delta <= sat34(delta_sum);
                r_est   <= sat34(est_sum);
            end
            if (i_cmd.range_ld) begin
                r_range <= i_range_reading;
                r_rerr  <= i_range_error;
                r_est   <= signed'({8'd0, i_range_reading, 8'd0});
            end
        end
    end

    assign o_accel        = r_accel;
    assign o_velocity     = r_vel;
    assign o_velocity_avg = r_avg;
    assign o_estimate     = r_est;
    assign o_delta        = r_delta;
    assign o_range        = r_range;
    assign o_range_error  = r_rerr;

endmodule

@@ sv/imu_tof_distance_estimator.sv @@
// ----------------------------------------------------------------------------
// IMU/ToF distance estimator top level
// Stream wrapper joining the controller, the datapath and the config registers.
// ----------------------------------------------------------------------------
// One item is in work at a time and the input is ready only while the block is
// idle. An IMU sample runs the bit-serial square root, then the acceleration
// scaling, the velocity multiply and add, the sum of the AVG_DEPTH-entry
// velocity ring and the averaging. A predict tick runs the predict multiply and
// add when the velocity is above the motion threshold and skips them otherwise;
// a range reading and the unused action go straight to the output. The result is
// presented in the cycle after that work and held until taken, and the input is
// ready again in the cycle after the result transfer.
module imu_tof_distance_estimator #(
    parameter int AVG_DEPTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[1:0]
    input  logic [1:0]   s_axis_tuser,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32],
    // range_reading[63:48], range_error[79:64]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // accel[31:0], velocity[63:32], velocity_avg[95:64], estimate[127:96],
    // delta[159:128], range[175:160], range_error[191:176]
    output logic [191:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    `include "imu_tof_distance_estimator_assert.svh"

    logic [15:0] r_delta_time, r_deadband, r_motion;
    itde_pkg::t_cmd    cmd;
    itde_pkg::t_status status;
    logic idle, out_valid, start;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_time <= 16'd655;
            r_deadband   <= 16'd500;
            r_motion     <= 16'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                itde_pkg::REG_DELTA_TIME: r_delta_time <= i_cfg_data;
                itde_pkg::REG_DEADBAND:   r_deadband   <= i_cfg_data;
                itde_pkg::REG_MOTION:     r_motion     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;
    assign m_axis_tvalid = out_valid;

    itde_ctrl #(.AVG_DEPTH(AVG_DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_action    (s_axis_tuser),
        .i_out_taken (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_idle      (idle),
        .o_out_valid (out_valid)
    );

    itde_dpath #(.AVG_DEPTH(AVG_DEPTH)) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_action           (s_axis_tuser),
        .i_accel_x          (s_axis_tdata[15:0]),
        .i_accel_y          (s_axis_tdata[31:16]),
        .i_accel_z          (s_axis_tdata[47:32]),
        .i_range_reading    (s_axis_tdata[63:48]),
        .i_range_error      (s_axis_tdata[79:64]),
        .i_delta_time       (r_delta_time),
        .i_deadband_limit   (r_deadband),
        .i_motion_threshold (r_motion),
        .o_status           (status),
        .o_accel            (m_axis_tdata[31:0]),
        .o_velocity         (m_axis_tdata[63:32]),
        .o_velocity_avg     (m_axis_tdata[95:64]),
        .o_estimate         (m_axis_tdata[127:96]),
        .o_delta            (m_axis_tdata[159:128]),
        .o_range            (m_axis_tdata[175:160]),
        .o_range_error      (m_axis_tdata[191:176])
    );

    // No input is taken while a result is pending.
    `ITDE_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    // A taken result returns the block to idle.
    `ITDE_ASSERT_NEXT(a_idle_after, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready, s_axis_tready)
    // A range reading reports its stored word on the next cycle.
    `ITDE_ASSERT_NEXT(a_range_ld, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tuser == itde_pkg::ACT_RANGE,
        m_axis_tdata[175:160] == $past(s_axis_tdata[63:48]))

endmodule
